FILE: rtl/svm_pkg.sv
package svm_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int NUM_VARS_DEF    = 16;
  localparam int DATA_W          = 32;
  localparam int IDX_W           = 4;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_ADD   = 3'd2,
    OP_SUB   = 3'd3,
    OP_MUL   = 3'd4,
    OP_DIV   = 3'd5,
    OP_STORE = 3'd6,
    OP_NOP   = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDEF = 3'd1,
    ST_NOVAL = 3'd2,
    ST_UNDER = 3'd3,
    ST_OVER  = 3'd4,
    ST_DIVZ  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    CL_NOP,
    CL_PUSH,
    CL_LOAD,
    CL_ALU,
    CL_STORE
  } op_class_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  // Decoded request as it travels from the front queue to the execute side.
  typedef struct packed {
    op_class_t          cls;
    alu_op_t            alu;
    logic [DATA_W-1:0]  imm;
    logic [IDX_W-1:0]   idx;
    logic               idx_ok;
    logic               start;
  } fr_item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_STORE,
    BK_RD_B,
    BK_RD_A,
    BK_EXEC,
    BK_DIV,
    BK_COMMIT
  } bk_state_t;

endpackage

FILE: rtl/stack_expression_vm_top.sv
// Path from accepted request to result: push, no-op, store to an empty stack and errors
// other than divide by zero are answered in the idle state; load and store pass through
// their own state; add, sub, mul and divide by zero read both operands in turn through the
// single stack RAM read port, then execute and commit; divide also waits on the divider.
// A 2-entry request queue decouples input from execute, which takes one request at a time.
// Reset: stack empty, result cleared, all variables undefined; RAMs not cleared.
module stack_expression_vm_top #(
  parameter int STACK_DEPTH = svm_pkg::STACK_DEPTH_DEF,
  parameter int NUM_VARS    = svm_pkg::NUM_VARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [31:0] immediate_value,
  input  logic [3:0]  var_index,
  input  logic        program_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] last_result,
  output logic        result_valid,
  output logic [2:0]  status
);

  import svm_pkg::*;

  fr_item_t q_item;
  logic     q_valid;
  logic     q_pop;

  svm_front #(.NUM_VARS(NUM_VARS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .immediate_value (immediate_value),
    .var_index       (var_index),
    .program_start   (program_start),
    .q_item          (q_item),
    .q_valid         (q_valid),
    .q_pop           (q_pop)
  );

  svm_back #(.STACK_DEPTH(STACK_DEPTH), .NUM_VARS(NUM_VARS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .last_result  (last_result),
    .result_valid (result_valid),
    .status       (status)
  );

`ifndef ASSERT_OFF
  a_no_result_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_valid |-> last_result == '0)
    else $error("last_result nonzero without a result in this program");

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("request taken from an empty queue");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented right after reset");
`endif

endmodule

FILE: rtl/svm_ram.sv
module svm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/svm_div.sv
module svm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  import svm_pkg::*;

  logic                busy;
  logic [4:0]          cnt;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   quo;
  logic [DATA_W-1:0]   dsr;
  logic                neg;
  logic [DATA_W+1:0]   trial;
  logic                fits;

  // Restoring divide on magnitudes, one quotient bit per cycle.
  assign trial = {1'b0, rem, quo[DATA_W-1]} - {2'b00, dsr};
  assign fits  = !trial[DATA_W+1];
  assign quotient = neg ? (DATA_W'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'(DATA_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      quo <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      dsr <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      rem <= fits ? trial[DATA_W-1:0] : {rem[DATA_W-2:0], quo[DATA_W-1]};
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/svm_front.sv
module svm_front #(
  parameter int NUM_VARS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [31:0]       immediate_value,
  input  logic [3:0]        var_index,
  input  logic              program_start,
  output svm_pkg::fr_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);

  import svm_pkg::*;

  fr_item_t   slots [2];
  fr_item_t   dec;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    dec.imm    = immediate_value;
    dec.idx    = var_index;
    dec.idx_ok = ({28'd0, var_index} < 32'(NUM_VARS));
    dec.start  = program_start;
    dec.alu    = ALU_ADD;
    dec.cls    = CL_NOP;
    unique case (opcode_t'(opcode))
      OP_PUSH:  dec.cls = CL_PUSH;
      OP_LOAD:  dec.cls = CL_LOAD;
      OP_ADD: begin
        dec.cls = CL_ALU;
        dec.alu = ALU_ADD;
      end
      OP_SUB: begin
        dec.cls = CL_ALU;
        dec.alu = ALU_SUB;
      end
      OP_MUL: begin
        dec.cls = CL_ALU;
        dec.alu = ALU_MUL;
      end
      OP_DIV: begin
        dec.cls = CL_ALU;
        dec.alu = ALU_DIV;
      end
      OP_STORE: dec.cls = CL_STORE;
      OP_NOP:   dec.cls = CL_NOP;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= dec;
    end
  end

endmodule

FILE: rtl/svm_back.sv
module svm_back #(
  parameter int STACK_DEPTH = 16,
  parameter int NUM_VARS    = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  svm_pkg::fr_item_t q_item,
  input  logic              q_valid,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       last_result,
  output logic              result_valid,
  output logic [2:0]        status
);

  import svm_pkg::*;

  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int VAW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  bk_state_t state, state_next;
  fr_item_t  cur;

  logic [DW-1:0]     depth, depth_next, depth_eff, dm1_eff, dm1, dm2;
  logic [DATA_W-1:0] opa, opb, res_tmp, result_reg, result_next;
  logic              result_seen, seen_next, divz;
  logic [NUM_VARS-1:0] var_defined, var_has;

  logic [VAW+IDX_W-1:0] qidx_ext, cidx_ext;
  logic [VAW-1:0]       q_vaddr, c_vaddr;
  logic                 def_hit, has_hit, full_eff, emit_ok;

  // classification of the request at the head of the queue
  logic    multi;
  status_t idle_st;

  // control
  logic              emit, clr, set;
  status_t           emit_status, out_status;
  logic [DATA_W-1:0] set_val;
  logic              stk_we, stk_re, var_we, var_re;
  logic [SAW-1:0]    stk_waddr, stk_raddr;
  logic [DATA_W-1:0] stk_wdata, stk_dout, var_dout;
  logic              flag_we, flag_has;
  logic [VAW-1:0]    flag_addr;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_q;

  svm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_dout)
  );

  svm_ram #(.WIDTH(DATA_W), .DEPTH(NUM_VARS)) u_vars (
    .clk     (clk),
    .wr_en   (var_we),
    .wr_addr (c_vaddr),
    .wr_data (stk_dout),
    .rd_en   (var_re),
    .rd_addr (q_vaddr),
    .rd_data (var_dout)
  );

  svm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_q)
  );

  assign qidx_ext  = {{VAW{1'b0}}, q_item.idx};
  assign cidx_ext  = {{VAW{1'b0}}, cur.idx};
  assign q_vaddr   = qidx_ext[VAW-1:0];
  assign c_vaddr   = cidx_ext[VAW-1:0];

  // program start empties the stack before the instruction looks at it
  assign depth_eff = q_item.start ? '0 : depth;
  assign dm1_eff   = depth_eff - DW'(1);
  assign dm1       = depth - DW'(1);
  assign dm2       = depth - DW'(2);
  assign full_eff  = (depth_eff == DW'(STACK_DEPTH));
  assign def_hit   = q_item.idx_ok && var_defined[q_vaddr];
  assign has_hit   = var_has[q_vaddr];
  assign emit_ok   = !out_valid || !out_stall;

  always_comb begin
    multi   = 1'b0;
    idle_st = ST_OK;
    unique case (q_item.cls)
      CL_PUSH: begin
        if (full_eff) idle_st = ST_OVER;
      end
      CL_LOAD: begin
        if (!def_hit)       idle_st = ST_UNDEF;
        else if (!has_hit)  idle_st = ST_NOVAL;
        else if (full_eff)  idle_st = ST_OVER;
        else                multi   = 1'b1;
      end
      CL_ALU: begin
        if (depth_eff < DW'(2)) idle_st = ST_UNDER;
        else                    multi   = 1'b1;
      end
      CL_STORE: begin
        if (!q_item.idx_ok)          idle_st = ST_UNDEF;
        else if (depth_eff != '0)    multi   = 1'b1;
      end
      CL_NOP: ;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && multi) begin
          if (q_item.cls == CL_LOAD)       state_next = BK_LOAD;
          else if (q_item.cls == CL_STORE) state_next = BK_STORE;
          else                             state_next = BK_RD_B;
        end
      end
      BK_LOAD, BK_STORE, BK_COMMIT: begin
        if (emit_ok) state_next = BK_IDLE;
      end
      BK_RD_B: state_next = BK_RD_A;
      BK_RD_A: state_next = BK_EXEC;
      BK_EXEC: state_next = div_start ? BK_DIV : BK_COMMIT;
      BK_DIV: begin
        if (div_done) state_next = BK_COMMIT;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop       = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    clr         = 1'b0;
    set         = 1'b0;
    set_val     = stk_dout;
    depth_next  = depth;
    stk_we      = 1'b0;
    stk_waddr   = depth[SAW-1:0];
    stk_wdata   = res_tmp;
    stk_re      = 1'b0;
    stk_raddr   = dm1_eff[SAW-1:0];
    var_we      = 1'b0;
    var_re      = 1'b0;
    flag_we     = 1'b0;
    flag_addr   = c_vaddr;
    flag_has    = 1'b0;
    div_start   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid && (multi || emit_ok)) begin
          q_pop      = 1'b1;
          clr        = q_item.start;
          depth_next = depth_eff;
          if (multi) begin
            var_re = (q_item.cls == CL_LOAD);
            stk_re = (q_item.cls != CL_LOAD);
          end else begin
            emit        = 1'b1;
            emit_status = idle_st;
            if (q_item.cls == CL_PUSH && idle_st == ST_OK) begin
              stk_we     = 1'b1;
              stk_waddr  = depth_eff[SAW-1:0];
              stk_wdata  = q_item.imm;
              depth_next = depth_eff + DW'(1);
            end
            // store with nothing stacked: defined, bound to no value
            if (q_item.cls == CL_STORE && idle_st == ST_OK) begin
              flag_we   = 1'b1;
              flag_addr = q_vaddr;
              flag_has  = 1'b0;
            end
          end
        end
      end
      BK_LOAD: begin
        if (emit_ok) begin
          emit       = 1'b1;
          stk_we     = 1'b1;
          stk_wdata  = var_dout;
          depth_next = depth + DW'(1);
          set        = 1'b1;
          set_val    = var_dout;
        end
      end
      BK_STORE: begin
        if (emit_ok) begin
          emit       = 1'b1;
          var_we     = 1'b1;
          flag_we    = 1'b1;
          flag_has   = 1'b1;
          depth_next = dm1;
          set        = 1'b1;
          set_val    = stk_dout;
        end
      end
      BK_RD_B: begin
        stk_re    = 1'b1;
        stk_raddr = dm2[SAW-1:0];
      end
      BK_RD_A: ;
      BK_EXEC: begin
        div_start = (cur.alu == ALU_DIV) && (opb != '0);
      end
      BK_DIV: ;
      BK_COMMIT: begin
        if (emit_ok) begin
          emit = 1'b1;
          if (divz) begin
            emit_status = ST_DIVZ;
          end else begin
            stk_we     = 1'b1;
            stk_waddr  = dm2[SAW-1:0];
            stk_wdata  = res_tmp;
            depth_next = dm1;
            set        = 1'b1;
            set_val    = res_tmp;
          end
        end
      end
      default: ;
    endcase
  end

  assign result_next = set ? set_val : (clr ? '0 : result_reg);
  assign seen_next   = set || (!clr && result_seen);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      depth       <= '0;
      result_reg  <= '0;
      result_seen <= 1'b0;
      var_defined <= '0;
      var_has     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      depth       <= depth_next;
      result_reg  <= result_next;
      result_seen <= seen_next;
      if (flag_we) begin
        var_defined[flag_addr] <= 1'b1;
        var_has[flag_addr]     <= flag_has;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (emit) begin
      last_result  <= result_next;
      result_valid <= seen_next;
      out_status   <= emit_status;
    end
    if (state == BK_RD_B) begin
      opb <= stk_dout;
    end
    if (state == BK_RD_A) begin
      opa <= stk_dout;
    end
    if (state == BK_EXEC) begin
      divz <= (cur.alu == ALU_DIV) && (opb == '0);
      case (cur.alu)
        ALU_ADD: res_tmp <= opa + opb;
        ALU_SUB: res_tmp <= opa - opb;
        ALU_MUL: res_tmp <= opa * opb;
        default: res_tmp <= res_tmp;
      endcase
    end
    if (state == BK_DIV && div_done) begin
      res_tmp <= div_q;
    end
  end

  assign status = out_status;

endmodule
